// File: hw/rtl/cvc_pkg.sv
// Package for the coin vending controller: payload types, phase codes and constants.
// No dependencies; coin_vend_controller.sv refers to it by scoped names.

package cvc_pkg;

  // Widths of the state and the configuration register.
  localparam int PHASE_W = 4;
  localparam int COUNT_W = 21;
  localparam int LIMIT_W = 20;
  localparam int HIST_W  = 8;
  localparam int NUM_BTN = 4;
  localparam int BTN_IDX_W = 2;

  // Reset values and the debouncer match pattern.
  localparam logic [HIST_W-1:0]  DEBOUNCE_RESET = 8'hFF;
  localparam logic [HIST_W-1:0]  DEBOUNCE_FIRE  = 8'h03;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 20'd1000000;

  // Button and lamp positions.
  localparam logic [BTN_IDX_W-1:0] BTN_SMALL   = 2'd0;
  localparam logic [BTN_IDX_W-1:0] BTN_LARGE   = 2'd1;
  localparam logic [BTN_IDX_W-1:0] BTN_PROCESS = 2'd2;
  localparam logic [BTN_IDX_W-1:0] BTN_CANCEL  = 2'd3;

  localparam logic [NUM_BTN-1:0] LAMP_NONE    = 4'b0000;
  localparam logic [NUM_BTN-1:0] LAMP_SMALL   = 4'b0001;
  localparam logic [NUM_BTN-1:0] LAMP_LARGE   = 4'b0010;
  localparam logic [NUM_BTN-1:0] LAMP_PROCESS = 4'b0100;
  localparam logic [NUM_BTN-1:0] LAMP_CANCEL  = 4'b1000;
  localparam logic [NUM_BTN-1:0] LAMP_ALL     = 4'b1111;

  // Phase codes of the vending sequence.
  localparam logic [PHASE_W-1:0] PH_START       = 4'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT500     = 4'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT1000    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_READY       = 4'd3;
  localparam logic [PHASE_W-1:0] PH_PROC_DELAY  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_CANCEL      = 4'd5;
  localparam logic [PHASE_W-1:0] PH_CANCEL_DLY  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_OUT         = 4'd7;
  localparam logic [PHASE_W-1:0] PH_OUT_DELAY   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_FINISH      = 4'd9;

  // Input transaction: raw button levels, 0 pressed, 1 released.
  typedef struct packed {
    logic pin_coin_small;
    logic pin_coin_large;
    logic pin_process;
    logic pin_cancel;
  } pins_t;

  // Output transaction: lamp levels and phase after the tick.
  typedef struct packed {
    logic               led_coin_small;
    logic               led_coin_large;
    logic               led_process;
    logic               led_cancel;
    logic [PHASE_W-1:0] phase;
  } status_t;

endpackage

// File: hw/rtl/cvc_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
// The payload type is a parameter; the controller uses the structs of cvc_pkg.

interface cvc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/coin_vend_controller.sv
// Coin vending controller: ten-phase vending sequence with four button debouncers.
// Depends on cvc_pkg and cvc_stream_if.
//
//  Channel   Direction  Payload            Meaning
//  pins      in         cvc_pkg::pins_t    raw button levels, one tick per transaction
//  status    out        cvc_pkg::status_t  lamp levels and phase after that tick
//  cfg_*     in         20-bit delay limit write-only register
//
// Each pins transaction is one tick: the next phase, counter, debouncer histories
// and lamps are computed combinationally and the result lands in the output register.
// A new transaction is taken every cycle while the output register is empty or
// being drained, so a stalled status channel holds pins back after one result.
// Reset (rst, synchronous) returns to the start phase, clears the counter and
// lamps, sets all histories to 0xFF and the limit to 1000000.

module coin_vend_controller (
  input  logic                          clk,
  input  logic                          rst,
  cvc_stream_if.sink                    pins,
  cvc_stream_if.source                  status,
  input  logic                          cfg_we,
  input  logic [cvc_pkg::LIMIT_W-1:0]   cfg_data
);

  // State registers.
  logic [cvc_pkg::PHASE_W-1:0] phase_reg, phase_next;
  logic [cvc_pkg::COUNT_W-1:0] delay_count, delay_count_next;
  logic [cvc_pkg::HIST_W-1:0]  hist [cvc_pkg::NUM_BTN];
  logic [cvc_pkg::HIST_W-1:0]  hist_next [cvc_pkg::NUM_BTN];
  logic [cvc_pkg::NUM_BTN-1:0] lamps, lamps_next;
  logic [cvc_pkg::LIMIT_W-1:0] delay_limit;

  // Output register.
  logic              out_valid;
  cvc_pkg::status_t  out_data;

  // Combinational helpers.
  logic [cvc_pkg::NUM_BTN-1:0] level;
  logic [cvc_pkg::HIST_W-1:0]  shifted [cvc_pkg::NUM_BTN];
  logic [cvc_pkg::NUM_BTN-1:0] fire;
  logic [cvc_pkg::COUNT_W-1:0] count_inc;
  logic                        delay_done;
  logic                        accept;

  assign pins.ready = !out_valid || status.ready;
  assign accept     = pins.valid && pins.ready;

  assign status.valid   = out_valid;
  assign status.payload = out_data;

  // Button levels by index.
  assign level[cvc_pkg::BTN_SMALL]   = pins.payload.pin_coin_small;
  assign level[cvc_pkg::BTN_LARGE]   = pins.payload.pin_coin_large;
  assign level[cvc_pkg::BTN_PROCESS] = pins.payload.pin_process;
  assign level[cvc_pkg::BTN_CANCEL]  = pins.payload.pin_cancel;

  // Candidate history of every debouncer and its fire condition.
  always_comb begin
    for (int i = 0; i < cvc_pkg::NUM_BTN; i++) begin
      shifted[i] = {hist[i][cvc_pkg::HIST_W-2:0], level[i]};
      fire[i]    = (shifted[i] == cvc_pkg::DEBOUNCE_FIRE);
    end
  end

  // Delay counter step.
  assign count_inc  = delay_count + cvc_pkg::COUNT_W'(1);
  assign delay_done = (count_inc > {1'b0, delay_limit});

  // Next-state logic for one tick; later checks override earlier ones.
  always_comb begin
    phase_next       = phase_reg;
    delay_count_next = delay_count;
    lamps_next       = lamps;
    for (int i = 0; i < cvc_pkg::NUM_BTN; i++) begin
      hist_next[i] = hist[i];
    end

    unique case (phase_reg)
      cvc_pkg::PH_START: begin
        lamps_next = cvc_pkg::LAMP_NONE;
        phase_next = cvc_pkg::PH_WAIT500;
      end
      cvc_pkg::PH_WAIT500: begin
        hist_next[cvc_pkg::BTN_SMALL] = shifted[cvc_pkg::BTN_SMALL];
        hist_next[cvc_pkg::BTN_LARGE] = shifted[cvc_pkg::BTN_LARGE];
        if (level[cvc_pkg::BTN_SMALL] || level[cvc_pkg::BTN_LARGE]) begin
          delay_count_next = '0;
        end
        if (fire[cvc_pkg::BTN_SMALL]) begin
          lamps_next = cvc_pkg::LAMP_SMALL;
          phase_next = cvc_pkg::PH_WAIT1000;
        end
        if (fire[cvc_pkg::BTN_LARGE]) begin
          lamps_next = cvc_pkg::LAMP_LARGE;
          phase_next = cvc_pkg::PH_READY;
        end
      end
      cvc_pkg::PH_WAIT1000: begin
        hist_next[cvc_pkg::BTN_SMALL]  = shifted[cvc_pkg::BTN_SMALL];
        hist_next[cvc_pkg::BTN_LARGE]  = shifted[cvc_pkg::BTN_LARGE];
        hist_next[cvc_pkg::BTN_CANCEL] = shifted[cvc_pkg::BTN_CANCEL];
        if (level[cvc_pkg::BTN_SMALL] || level[cvc_pkg::BTN_LARGE] ||
            level[cvc_pkg::BTN_CANCEL]) begin
          delay_count_next = '0;
        end
        if (fire[cvc_pkg::BTN_SMALL] || fire[cvc_pkg::BTN_LARGE]) begin
          lamps_next = cvc_pkg::LAMP_LARGE;
          phase_next = cvc_pkg::PH_READY;
        end
        if (fire[cvc_pkg::BTN_CANCEL]) begin
          phase_next = cvc_pkg::PH_CANCEL;
        end
      end
      cvc_pkg::PH_READY: begin
        hist_next[cvc_pkg::BTN_PROCESS] = shifted[cvc_pkg::BTN_PROCESS];
        hist_next[cvc_pkg::BTN_CANCEL]  = shifted[cvc_pkg::BTN_CANCEL];
        if (level[cvc_pkg::BTN_PROCESS] || level[cvc_pkg::BTN_CANCEL]) begin
          delay_count_next = '0;
        end
        if (fire[cvc_pkg::BTN_PROCESS]) begin
          lamps_next = cvc_pkg::LAMP_PROCESS;
          phase_next = cvc_pkg::PH_PROC_DELAY;
        end
        if (fire[cvc_pkg::BTN_CANCEL]) begin
          phase_next = cvc_pkg::PH_CANCEL;
        end
      end
      cvc_pkg::PH_PROC_DELAY: begin
        delay_count_next = delay_done ? '0 : count_inc;
        if (delay_done) begin
          phase_next = cvc_pkg::PH_OUT;
        end
      end
      cvc_pkg::PH_CANCEL: begin
        lamps_next = cvc_pkg::LAMP_CANCEL;
        phase_next = cvc_pkg::PH_CANCEL_DLY;
      end
      cvc_pkg::PH_CANCEL_DLY, cvc_pkg::PH_OUT_DELAY: begin
        delay_count_next = delay_done ? '0 : count_inc;
        if (delay_done) begin
          phase_next = cvc_pkg::PH_FINISH;
        end
      end
      cvc_pkg::PH_OUT: begin
        // All lamps on, and the out delay already counts this tick.
        lamps_next       = cvc_pkg::LAMP_ALL;
        delay_count_next = delay_done ? '0 : count_inc;
        phase_next       = delay_done ? cvc_pkg::PH_FINISH : cvc_pkg::PH_OUT_DELAY;
      end
      default: begin
        // Finish and unused codes return to start with lamps kept.
        phase_next = cvc_pkg::PH_START;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_limit <= cvc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      delay_limit <= cfg_data;
    end
  end

  // State update on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= cvc_pkg::PH_START;
      delay_count <= '0;
      lamps       <= cvc_pkg::LAMP_NONE;
      for (int i = 0; i < cvc_pkg::NUM_BTN; i++) begin
        hist[i] <= cvc_pkg::DEBOUNCE_RESET;
      end
    end else if (accept) begin
      phase_reg   <= phase_next;
      delay_count <= delay_count_next;
      lamps       <= lamps_next;
      for (int i = 0; i < cvc_pkg::NUM_BTN; i++) begin
        hist[i] <= hist_next[i];
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.led_coin_small <= lamps_next[cvc_pkg::BTN_SMALL];
      out_data.led_coin_large <= lamps_next[cvc_pkg::BTN_LARGE];
      out_data.led_process    <= lamps_next[cvc_pkg::BTN_PROCESS];
      out_data.led_cancel     <= lamps_next[cvc_pkg::BTN_CANCEL];
      out_data.phase          <= phase_next;
    end
  end

endmodule
